@@ rtl/lru_frame_replacement_core_macros.svh @@
// Assertion macros for the LRU frame replacement core.
// Used by files that check their own logic; expects clk_i and rst_ni in scope.
`ifndef LRU_FRAME_REPLACEMENT_CORE_MACROS_SVH
`define LRU_FRAME_REPLACEMENT_CORE_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define LFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define LFR_ASSERT_NEXT(label, ante, cons, msg) \
  `LFR_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/lfr_pkg.sv @@
// Shared types, constants and helper functions for the LRU frame replacement core.
// No dependencies; the core top level, lfr_datapath and lfr_ctrl refer to it by scoped names.
`default_nettype none

package lfr_pkg;

  localparam int unsigned MaxFrames = 64;
  localparam int unsigned FrameW    = 6;
  localparam int unsigned CountW    = 7;

  typedef logic [FrameW-1:0] frame_t;
  typedef logic [CountW-1:0] count_t;

  localparam count_t MinFramesInUse = count_t'(2);
  localparam count_t MaxFramesInUse = count_t'(MaxFrames);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_item;
    logic write_unlink;
    logic write_push;
    logic write_finish;
  } lfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic out_free;
  } lfr_status_t;

  // Newer link of a frame right after the order is rebuilt.
  function automatic frame_t newer_reset(frame_t a);
    return (a == '0) ? '0 : frame_t'(a - 1'b1);
  endfunction

  // Older link of a frame right after the order is rebuilt.
  function automatic frame_t older_reset(frame_t a);
    return (a == frame_t'(MaxFrames - 1)) ? '0 : frame_t'(a + 1'b1);
  endfunction

  function automatic count_t clamp_count(count_t v);
    count_t r;
    r = v;
    if (v < MinFramesInUse) begin
      r = MinFramesInUse;
    end else if (v > MaxFramesInUse) begin
      r = MaxFramesInUse;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lru_frame_replacement_core.sv @@
// Top level of the LRU frame replacement core: controller plus datapath.
// Uses lfr_pkg, lfr_ctrl, lfr_datapath and lru_frame_replacement_core_macros.svh.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    action_i, frame_index_i
//   out      output     out_valid_o / out_ready_i  victim_frame_o, victim_valid_o,
//                                                  bad_index_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_frames_in_use_i
//
// One item at a time. A reference that moves a frame, and every evict, goes
// through read, unlink, push and finish steps on the single write port of each
// link memory before the next transfer. A bad reference or a reference of the
// newest frame goes from the read step straight to the finish step.
// Reset and a frame-count write rebuild the order at once through per-entry
// valid bits. The finish step holds while the result register is still full.
`default_nettype none

`include "lru_frame_replacement_core_macros.svh"

module lru_frame_replacement_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire lfr_pkg::count_t cfg_frames_in_use_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            action_i,
  input  wire lfr_pkg::frame_t frame_index_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lfr_pkg::frame_t      victim_frame_o,
  output logic                 victim_valid_o,
  output logic                 bad_index_o
);

  lfr_pkg::lfr_cmd_t    cmd;
  lfr_pkg::lfr_status_t status;

  assign cfg_ready_o = 1'b1;

  lfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_frames_i   (cfg_frames_in_use_i),
    .action_i       (action_i),
    .frame_index_i  (frame_index_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .victim_frame_o (victim_frame_o),
    .victim_valid_o (victim_valid_o),
    .bad_index_o    (bad_index_o)
  );

  // An item is worked on alone: no second transfer right after the first.
  `LFR_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "item taken while busy")
  // An evict result never carries the bad-index flag.
  `LFR_ASSERT(a_flags_exclusive, !(out_valid_o && victim_valid_o && bad_index_o), "both flags set")
  // A reference result reports frame zero as its victim.
  `LFR_ASSERT(a_ref_no_victim,
              !(out_valid_o && !victim_valid_o && (victim_frame_o != '0)), "victim on reference")
  // The datapath only finishes into a free result register.
  `LFR_ASSERT(a_finish_free, !cmd.write_finish || status.out_free, "result overwritten")

endmodule

`default_nettype wire

@@ rtl/lfr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/lfr_datapath.sv @@
// Datapath of the LRU frame replacement core: link memories, list ends,
// frame count, item registers and the result register. Uses lfr_pkg and lfr_ram.
`default_nettype none

module lfr_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lfr_pkg::lfr_cmd_t   cmd_i,
  output lfr_pkg::lfr_status_t     status_o,
  input  wire logic                cfg_write_i,
  input  wire lfr_pkg::count_t     cfg_frames_i,
  input  wire logic                action_i,
  input  wire lfr_pkg::frame_t     frame_index_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output lfr_pkg::frame_t          victim_frame_o,
  output logic                     victim_valid_o,
  output logic                     bad_index_o
);

  lfr_pkg::count_t frames_q;
  lfr_pkg::frame_t newest_q, oldest_q;
  logic [lfr_pkg::MaxFrames-1:0] newer_vld_q, older_vld_q;

  // Item registers: the target frame is the victim for an evict.
  lfr_pkg::frame_t item_q;
  logic evict_q, bad_q, skip_q, at_oldest_q;

  lfr_pkg::frame_t rd_addr_q;
  logic newer_rv_q, older_rv_q;
  lfr_pkg::frame_t newer_rdata, older_rdata;
  lfr_pkg::frame_t nw, od;

  logic            newer_we, older_we;
  lfr_pkg::frame_t newer_waddr, newer_wdata, older_waddr, older_wdata;

  logic out_valid_q, victim_valid_q, bad_index_q;
  lfr_pkg::frame_t victim_frame_q;
  lfr_pkg::count_t cfg_clamped;

  assign cfg_clamped = lfr_pkg::clamp_count(cfg_frames_i);

  // Entries not written since the order was rebuilt read as their rebuilt value.
  assign nw = newer_rv_q ? newer_rdata : lfr_pkg::newer_reset(rd_addr_q);
  assign od = older_rv_q ? older_rdata : lfr_pkg::older_reset(rd_addr_q);

  always_comb begin
    newer_we    = 1'b0;
    newer_waddr = item_q;
    newer_wdata = '0;
    older_we    = 1'b0;
    older_waddr = item_q;
    older_wdata = newest_q;
    if (cmd_i.write_unlink && !at_oldest_q) begin
      newer_we    = 1'b1;
      newer_waddr = od;
      newer_wdata = nw;
      older_we    = 1'b1;
      older_waddr = nw;
      older_wdata = od;
    end else if (cmd_i.write_push) begin
      newer_we    = 1'b1;
      newer_waddr = newest_q;
      newer_wdata = item_q;
      older_we    = 1'b1;
      older_waddr = item_q;
      older_wdata = newest_q;
    end else if (cmd_i.write_finish && !skip_q) begin
      newer_we    = 1'b1;
      newer_waddr = item_q;
      newer_wdata = '0;
    end
  end

  lfr_ram #(
    .Width (lfr_pkg::FrameW),
    .Depth (lfr_pkg::MaxFrames)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (newer_we),
    .waddr_i (newer_waddr),
    .wdata_i (newer_wdata),
    .raddr_i (item_q),
    .rdata_o (newer_rdata)
  );

  lfr_ram #(
    .Width (lfr_pkg::FrameW),
    .Depth (lfr_pkg::MaxFrames)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (older_we),
    .waddr_i (older_waddr),
    .wdata_i (older_wdata),
    .raddr_i (item_q),
    .rdata_o (older_rdata)
  );

  // List state and link valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= lfr_pkg::MaxFramesInUse;
      newest_q    <= '0;
      oldest_q    <= lfr_pkg::frame_t'(lfr_pkg::MaxFramesInUse - 1'b1);
      newer_vld_q <= '0;
      older_vld_q <= '0;
    end else if (cfg_write_i) begin
      frames_q    <= cfg_clamped;
      newest_q    <= '0;
      oldest_q    <= lfr_pkg::frame_t'(cfg_clamped - 1'b1);
      newer_vld_q <= '0;
      older_vld_q <= '0;
    end else begin
      if (newer_we) begin
        newer_vld_q[newer_waddr] <= 1'b1;
      end
      if (older_we) begin
        older_vld_q[older_waddr] <= 1'b1;
      end
      if (cmd_i.write_unlink && at_oldest_q) begin
        oldest_q <= nw;
      end
      if (cmd_i.write_finish && !skip_q) begin
        newest_q <= item_q;
      end
    end
  end

  // Item and read-side registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q      <= action_i ? oldest_q : frame_index_i;
      evict_q     <= action_i;
      bad_q       <= !action_i && ({1'b0, frame_index_i} >= frames_q);
      skip_q      <= !action_i && (({1'b0, frame_index_i} >= frames_q) ||
                                   (frame_index_i == newest_q));
      at_oldest_q <= action_i || (frame_index_i == oldest_q);
    end
    rd_addr_q  <= item_q;
    newer_rv_q <= newer_vld_q[item_q];
    older_rv_q <= older_vld_q[item_q];
  end

  // Result register: a finished result waits here while the next item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write_finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_finish) begin
      victim_frame_q <= evict_q ? item_q : '0;
      victim_valid_q <= evict_q;
      bad_index_q    <= bad_q;
    end
  end

  assign status_o.skip     = skip_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign victim_frame_o = victim_frame_q;
  assign victim_valid_o = victim_valid_q;
  assign bad_index_o    = bad_index_q;

endmodule

`default_nettype wire

@@ rtl/lfr_ctrl.sv @@
// Controller of the LRU frame replacement core: sequences the link reads and
// writes of one item at a time. Uses lfr_pkg.
`default_nettype none

module lfr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lfr_pkg::lfr_status_t status_i,
  output lfr_pkg::lfr_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UNLINK,
    ST_PUSH,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      // Link data arrives in the cycle after the read is issued.
      ST_READ:   state_d = status_i.skip ? ST_FINISH : ST_UNLINK;
      ST_UNLINK: state_d = ST_PUSH;
      ST_PUSH:   state_d = ST_FINISH;
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o          = (state_q == ST_IDLE);
  assign cmd_o.latch_item    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.write_unlink  = (state_q == ST_UNLINK);
  assign cmd_o.write_push    = (state_q == ST_PUSH);
  assign cmd_o.write_finish  = (state_q == ST_FINISH) && status_i.out_free;

endmodule

`default_nettype wire
